/* rtl/core/gtp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and helper functions of the go-to-pose controller.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;

  localparam int IDX_W     = $clog2(CORDIC_STEPS);
  localparam int XY_W      = 37;
  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 16;
  localparam int YT_W      = 16 + ANGLE_BITS;
  localparam int ATAN_SH   = 32 - ANGLE_BITS;

  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(652032874);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam logic [2:0] REG_V_LINEAR = 3'd0;
  localparam logic [2:0] REG_V_ROT    = 3'd1;
  localparam logic [2:0] REG_SLOWDOWN = 3'd2;
  localparam logic [2:0] REG_D_STOP   = 3'd3;
  localparam logic [2:0] REG_D_SLOW   = 3'd4;
  localparam logic [2:0] REG_A_STOP   = 3'd5;
  localparam logic [2:0] REG_A_SLOW   = 3'd6;

  localparam logic OP_GOAL = 1'b0;
  localparam logic OP_ODOM = 1'b1;

  typedef enum logic [1:0] {
    M_STOP = 2'd0,
    M_MOVE = 2'd1,
    M_SLOW = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR, ST_FSM, ST_VEC, ST_RPRE, ST_ROT, ST_MUL, ST_DLD, ST_DIV, ST_OUT
  } seq_t;

  typedef enum logic [1:0] {
    JOB_X, JOB_Y, JOB_T
  } job_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_sts_t;

  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

  // round the per-step angle to the internal angle scale
  function automatic logic [ANGLE_BITS-1:0] atan_at(input logic [4:0] i);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (ATAN_SH - 1));
    return ANGLE_BITS'(t >> ATAN_SH);
  endfunction

  // later test wins within a state
  function automatic mode_t step_fsm(input mode_t st, input logic ge_stop,
                                     input logic le_stop, input logic ge_slow,
                                     input logic le_slow);
    mode_t n;
    n = st;
    unique case (st)
      M_MOVE: begin
        if (le_slow && ge_stop) n = M_SLOW;
        if (le_stop) n = M_STOP;
      end
      M_SLOW: begin
        if (le_stop) n = M_STOP;
        if (ge_slow) n = M_MOVE;
      end
      default: begin
        n = M_STOP;
        if (ge_slow) n = M_MOVE;
        if (ge_stop && le_slow) n = M_SLOW;
      end
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/gtp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtp_in_if
// Input channel: goal or odometry pose beats.
// ----------------------------------------------------------------------------
interface gtp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] yaw;

  modport source (output valid, output opcode, output pos_x, output pos_y,
                  output yaw, input ready);
  modport sink (input valid, input opcode, input pos_x, input pos_y,
                input yaw, output ready);
endinterface
`default_nettype wire

/* rtl/core/gtp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtp_out_if
// Result channel: velocity command beats.
// ----------------------------------------------------------------------------
interface gtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] turn_rate;
  logic [1:0]         linear_mode;
  logic [1:0]         rotate_mode;

  modport source (output valid, output vel_x, output vel_y, output turn_rate,
                  output linear_mode, output rotate_mode, input ready);
  modport sink (input valid, input vel_x, input vel_y, input turn_rate,
                input linear_mode, input rotate_mode, output ready);
endinterface
`default_nettype wire

/* rtl/core/go_to_pose_velocity_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// Goal beat: taken while idle, ready stays high, no result.
// Odometry beat: squaring and a mode step only when both axes stop; when
// both move, also CORDIC vectoring and rotation, then up to three scaled
// commands, each set by the 35-bit bit-serial divider.
// One beat is worked on at a time; ready is high only in the idle state.
// Synchronous active-low reset clears goal, modes and config to defaults.
// ----------------------------------------------------------------------------
// go_to_pose_velocity_controller
// Distance/heading mode machines with CORDIC bearing and body-frame command.
// ----------------------------------------------------------------------------
module go_to_pose_velocity_controller (
  input  logic        clk,
  input  logic        rst_n,
  gtp_in_if.sink      in_chan,
  gtp_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gtp_pkg::*;

  // configuration registers
  logic [23:0] v_lin_r, v_rot_r;
  logic [15:0] slowdown_r;
  logic [30:0] d_stop_r, d_slow_r;
  logic [15:0] a_stop_r, a_slow_r;

  // goal and per-beat working state
  logic signed [31:0] goal_x_r, goal_y_r;
  logic signed [15:0] goal_yaw_r;
  logic signed [32:0] dx_r, dy_r;
  logic [31:0]        adx_r, ady_r;
  logic               far_r, zero_r, err_pos_r;
  logic [16:0]        aerr_r;
  logic [ANGLE_BITS-1:0] yint_r;
  logic [63:0]        d2_r;
  logic               ds_ge_r, ds_le_r;
  mode_t              lin_r, rot_r;

  // shared CORDIC datapath
  logic signed [XY_W-1:0] x_r, y_r;
  logic [ANGLE_BITS-1:0]  z_r;

  // sequencer
  seq_t             st_r, st_nxt;
  logic [IDX_W-1:0] cnt_r;
  job_t             job_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_r;

  // divider hookup
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  div_sts_t             div_sts;

  // results
  logic signed [31:0] res_x_r, res_y_r, res_t_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_t_r;
  logic [1:0]         out_lm_r, out_rm_r;

  logic in_acc, cfg_wr, out_load;

  // --------------------------------------------------------------------------
  // Configuration port: writes land in the access phase, reads are immediate
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_lin_r    <= 24'd13107;
      v_rot_r    <= 24'd13107;
      slowdown_r <= 16'd512;
      d_stop_r   <= 31'd6554;
      d_slow_r   <= 31'd19661;
      a_stop_r   <= 16'd522;
      a_slow_r   <= 16'd1043;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_V_LINEAR: v_lin_r    <= pwdata[23:0];
        REG_V_ROT:    v_rot_r    <= pwdata[23:0];
        REG_SLOWDOWN: slowdown_r <= pwdata[15:0];
        REG_D_STOP:   d_stop_r   <= pwdata[30:0];
        REG_D_SLOW:   d_slow_r   <= pwdata[30:0];
        REG_A_STOP:   a_stop_r   <= pwdata[15:0];
        REG_A_SLOW:   a_slow_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_V_LINEAR: prdata = {8'd0, v_lin_r};
      REG_V_ROT:    prdata = {8'd0, v_rot_r};
      REG_SLOWDOWN: prdata = {16'd0, slowdown_r};
      REG_D_STOP:   prdata = {1'b0, d_stop_r};
      REG_D_SLOW:   prdata = {1'b0, d_slow_r};
      REG_A_STOP:   prdata = {16'd0, a_stop_r};
      REG_A_SLOW:   prdata = {16'd0, a_slow_r};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Beat capture: offsets to goal, wrapped heading error, yaw on angle scale
  // --------------------------------------------------------------------------
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        adx_c, ady_c;
  logic signed [17:0] err_c, errw_c;
  logic signed [YT_W-1:0] yext_c;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign dx_c   = {goal_x_r[31], goal_x_r} - {in_chan.pos_x[31], in_chan.pos_x};
  assign dy_c   = {goal_y_r[31], goal_y_r} - {in_chan.pos_y[31], in_chan.pos_y};
  assign adx_c  = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign ady_c  = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
  assign err_c  = {{2{goal_yaw_r[15]}}, goal_yaw_r} - {{2{in_chan.yaw[15]}}, in_chan.yaw};
  assign yext_c = YT_W'(in_chan.yaw);

  always_comb begin
    errw_c = err_c;
    if (err_c > 18'sd32768) errw_c = err_c - 18'sd65536;
    if (err_c < -18'sd32768) errw_c = err_c + 18'sd65536;
  end

  // --------------------------------------------------------------------------
  // Shared CORDIC step: vectoring drives y to zero, rotation drives z to zero
  // --------------------------------------------------------------------------
  logic signed [XY_W-1:0] sh_x, sh_y, x_step, y_step;
  logic [ANGLE_BITS-1:0]  at_c, z_step;
  logic                   sig_pos;

  assign sh_x    = x_r >>> cnt_r;
  assign sh_y    = y_r >>> cnt_r;
  assign at_c    = atan_at(5'(cnt_r));
  assign sig_pos = (st_r == ST_VEC) ? !(y_r > 0) : !z_r[ANGLE_BITS-1];
  assign x_step  = sig_pos ? x_r - sh_y : x_r + sh_y;
  assign y_step  = sig_pos ? y_r + sh_x : y_r - sh_x;
  assign z_step  = sig_pos ? z_r - at_c : z_r + at_c;

  // relative angle and its half-turn pre-rotation
  logic [ANGLE_BITS-1:0] bear_c, rel_c;
  logic                  flip_c;

  assign bear_c = zero_r ? '0 : z_r;
  assign rel_c  = bear_c - yint_r;
  assign flip_c = ($signed(rel_c) > QUARTER) || ($signed(rel_c) < -QUARTER);

  // --------------------------------------------------------------------------
  // Command scaling: |trig| * v, then divider, then sign and saturate
  // --------------------------------------------------------------------------
  logic signed [XY_W-1:0] ax_c, ay_c;
  logic [15:0]            dsel_c, deff_c;
  logic [64:0]            num_c;
  logic                   neg_c;
  logic [31:0]            sat_c;
  mode_t                  jmode_c;

  assign ax_c = x_r[XY_W-1] ? -x_r : x_r;
  assign ay_c = y_r[XY_W-1] ? -y_r : y_r;

  always_comb begin
    jmode_c = (job_r == JOB_T) ? rot_r : lin_r;
    dsel_c  = (jmode_c == M_SLOW) ? slowdown_r : 16'd256;
    deff_c  = (dsel_c == '0) ? 16'd1 : dsel_c;
  end

  // |trig| * v stays below 2^55, so the top product bits are always zero here
  assign num_c   = {mul_r[56:0], 8'd0} + (65'(deff_c) << 29);
  assign div_num = num_c[64:30];
  assign div_den = deff_c;

  always_comb begin
    unique case (job_r)
      JOB_X:   neg_c = x_r[XY_W-1];
      JOB_Y:   neg_c = y_r[XY_W-1];
      default: neg_c = !err_pos_r;
    endcase
    if (neg_c) begin
      sat_c = (div_sts.quo > DIV_NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                          : 32'd0 - div_sts.quo[31:0];
    end else begin
      sat_c = (div_sts.quo > DIV_NUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : div_sts.quo[31:0];
    end
  end

  gtp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .sts      (div_sts)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  logic  last_step;
  mode_t lin_nx_c, rot_nx_c;
  logic  as_ge, as_le, al_ge, al_le, dl_ge, dl_le;

  assign last_step = (cnt_r == IDX_W'(CORDIC_STEPS - 1));
  assign out_load  = (st_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  assign as_ge = aerr_r >= {1'b0, a_stop_r};
  assign as_le = aerr_r <= {1'b0, a_stop_r};
  assign al_ge = aerr_r >= {1'b0, a_slow_r};
  assign al_le = aerr_r <= {1'b0, a_slow_r};
  assign dl_ge = far_r || (d2_r >= mul_r);
  assign dl_le = !far_r && (d2_r <= mul_r);
  assign lin_nx_c = step_fsm(lin_r, ds_ge_r, ds_le_r, dl_ge, dl_le);
  assign rot_nx_c = step_fsm(rot_r, as_ge, as_le, al_ge, al_le);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc && in_chan.opcode != OP_GOAL) st_nxt = ST_SQR;
      ST_SQR:  if (cnt_r == IDX_W'(3)) st_nxt = ST_FSM;
      ST_FSM: begin
        if (lin_nx_c != M_STOP)      st_nxt = ST_VEC;
        else if (rot_nx_c != M_STOP) st_nxt = ST_MUL;
        else                         st_nxt = ST_OUT;
      end
      ST_VEC:  if (last_step) st_nxt = ST_RPRE;
      ST_RPRE: st_nxt = ST_ROT;
      ST_ROT:  if (last_step) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_DLD;
      ST_DLD:  st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_sts.done) begin
          if (job_r == JOB_X)                         st_nxt = ST_MUL;
          else if (job_r == JOB_Y && rot_r != M_STOP) st_nxt = ST_MUL;
          else                                        st_nxt = ST_OUT;
        end
      end
      ST_OUT:  if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs (multiplier operands, divider start, ready)
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (st_r)
      ST_SQR: begin
        unique case (cnt_r)
          IDX_W'(0): begin mul_a = adx_r;            mul_b = adx_r;            end
          IDX_W'(1): begin mul_a = ady_r;            mul_b = ady_r;            end
          IDX_W'(2): begin mul_a = {1'b0, d_stop_r}; mul_b = {1'b0, d_stop_r}; end
          IDX_W'(3): begin mul_a = {1'b0, d_slow_r}; mul_b = {1'b0, d_slow_r}; end
          default: ;
        endcase
      end
      ST_MUL: begin
        unique case (job_r)
          JOB_X:   begin mul_a = ax_c[31:0];   mul_b = {8'd0, v_lin_r}; end
          JOB_Y:   begin mul_a = ay_c[31:0];   mul_b = {8'd0, v_lin_r}; end
          default: begin mul_a = 32'h4000_0000; mul_b = {8'd0, v_rot_r}; end
        endcase
      end
      ST_DLD:  div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_chan.ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      lin_r       <= M_STOP;
      rot_r       <= M_STOP;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_yaw_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_FSM) begin
        lin_r <= lin_nx_c;
        rot_r <= rot_nx_c;
      end
      // goal beat: hold the new target
      if (in_acc && in_chan.opcode == OP_GOAL) begin
        goal_x_r   <= in_chan.pos_x;
        goal_y_r   <= in_chan.pos_y;
        goal_yaw_r <= in_chan.yaw;
      end
      if (out_load)            out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // ST_FSM updates the modes from the stop compare registered in ST_SQR and
  // the slow compare made in ST_FSM (step_fsm reads the old mode there)

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r     <= '0;
      dx_r      <= dx_c;
      dy_r      <= dy_c;
      adx_r     <= adx_c[31:0];
      ady_r     <= ady_c[31:0];
      far_r     <= adx_c[32] | adx_c[31] | ady_c[32] | ady_c[31];
      zero_r    <= (dx_c == '0) && (dy_c == '0);
      err_pos_r <= errw_c > 18'sd0;
      aerr_r    <= errw_c[17] ? 17'(-errw_c) : 17'(errw_c);
      yint_r    <= ANGLE_BITS'((yext_c <<< ANGLE_BITS) >>> 16);
    end

    unique case (st_r)
      ST_SQR: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IDX_W'(1)) d2_r <= mul_r;
        if (cnt_r == IDX_W'(2)) d2_r <= d2_r + mul_r;
        if (cnt_r == IDX_W'(3)) begin
          ds_ge_r <= far_r || (d2_r >= mul_r);
          ds_le_r <= !far_r && (d2_r <= mul_r);
        end
      end
      ST_FSM: begin
        cnt_r   <= '0;
        res_x_r <= '0;
        res_y_r <= '0;
        res_t_r <= '0;
        job_r   <= (lin_nx_c != M_STOP) ? JOB_X : JOB_T;
        // half-turn pre-rotation for goals behind the origin
        if (dx_r[32]) begin
          x_r <= XY_W'(-dx_r);
          y_r <= XY_W'(-dy_r);
          z_r <= HALF_TURN;
        end else begin
          x_r <= XY_W'(dx_r);
          y_r <= XY_W'(dy_r);
          z_r <= '0;
        end
      end
      ST_VEC, ST_ROT: begin
        x_r   <= x_step;
        y_r   <= y_step;
        z_r   <= z_step;
        cnt_r <= last_step ? '0 : cnt_r + 1'b1;
      end
      ST_RPRE: begin
        x_r <= flip_c ? -INV_GAIN : INV_GAIN;
        y_r <= '0;
        z_r <= flip_c ? rel_c - HALF_TURN : rel_c;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          unique case (job_r)
            JOB_X: begin res_x_r <= sat_c; job_r <= JOB_Y; end
            JOB_Y: begin res_y_r <= sat_c; job_r <= JOB_T; end
            default: res_t_r <= sat_c;
          endcase
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_x_r  <= res_x_r;
      out_y_r  <= res_y_r;
      out_t_r  <= res_t_r;
      out_lm_r <= lin_r;
      out_rm_r <= rot_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.vel_x       = out_x_r;
  assign out_chan.vel_y       = out_y_r;
  assign out_chan.turn_rate   = out_t_r;
  assign out_chan.linear_mode = out_lm_r;
  assign out_chan.rotate_mode = out_rm_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_lin_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lm_r == M_STOP |-> out_x_r == '0 && out_y_r == '0)
    else $error("linear stop with non-zero velocity");

  a_rot_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rm_r == M_STOP |-> out_t_r == '0)
    else $error("rotate stop with non-zero turn rate");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_odom_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.opcode != OP_GOAL |=> !in_chan.ready)
    else $error("odometry beat did not start the sequencer");

endmodule
`default_nettype wire

/* rtl/core/gtp_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gtp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gtp_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [gtp_pkg::DIV_DEN_W-1:0] divisor,
  output gtp_pkg::div_sts_t          sts
);
  import gtp_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : DIV_DEN_W'(trial);
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.quo  = quo_r;

endmodule
`default_nettype wire

/* bench/gtp_cmd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_cmd_checker
// Watches the pose, command and register traffic of the go-to-pose controller,
// predicts every velocity command from its own copy of goal, modes and
// registers, and compares each command beat field by field.
// ----------------------------------------------------------------------------
module gtp_cmd_checker (
  input  logic        clk,
  input  logic        rst_n,
  gtp_in_if           pose_mon,
  gtp_out_if          cmd_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          cmds_pending,
  output int          cmds_checked
);
  import gtp_pkg::*;

  localparam int AB = ANGLE_BITS;

  localparam longint ATAN32 [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct {
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] turn_rate;
    logic [1:0]  lin;
    logic [1:0]  rot;
  } command_t;

  command_t cmd_q[$];

  longint unsigned v_lin, v_turn, slow_div, d_stop, d_slow, a_stop, a_slow;
  longint goal_x, goal_y, goal_yaw;
  mode_t  lin_mode, rot_mode;

  function automatic longint wrap_turn(longint a);
    longint full, u;
    full = longint'(1) << AB;
    u = a & (full - 1);
    if (u >= full / 2) u -= full;
    return u;
  endfunction

  function automatic longint step_angle(int i);
    return (ATAN32[i % 32] + (longint'(1) << (31 - AB))) >> (32 - AB);
  endfunction

  function automatic int cmp_mag(longint unsigned a, longint unsigned b);
    return a > b ? 1 : (a < b ? -1 : 0);
  endfunction

  function automatic mode_t next_mode(mode_t st, int c_stop, int c_slow);
    mode_t n;
    n = st;
    if (st == M_MOVE) begin
      if (c_slow <= 0 && c_stop >= 0) n = M_SLOW;
      if (c_stop <= 0) n = M_STOP;
    end else if (st == M_SLOW) begin
      if (c_stop <= 0) n = M_STOP;
      if (c_slow >= 0) n = M_MOVE;
    end else begin
      n = M_STOP;
      if (c_slow >= 0) n = M_MOVE;
      if (c_stop >= 0 && c_slow <= 0) n = M_SLOW;
    end
    return n;
  endfunction

  function automatic longint heading_to_goal(longint dx, longint dy);
    longint x, y, z, nx;
    if (dx == 0 && dy == 0) return 0;
    x = dx;
    y = dy;
    z = 0;
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = longint'(1) << (AB - 1);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += step_angle(i);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= step_angle(i);
      end
      x = nx;
    end
    return wrap_turn(z);
  endfunction

  function automatic void unit_vector(longint ang, output longint c, output longint s);
    longint x, y, z, nx, q;
    x = 652032874;
    y = 0;
    q = longint'(1) << (AB - 2);
    z = wrap_turn(ang);
    if (z > q || z < -q) begin
      x = -x;
      z = wrap_turn(z - (longint'(1) << (AB - 1)));
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= step_angle(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += step_angle(i);
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  // round half away from zero, then saturate to 32 bits
  function automatic logic [31:0] scaled_command(longint c, longint unsigned v,
                                                 longint unsigned d);
    longint unsigned mag, den, q;
    logic [31:0] r;
    mag = c < 0 ? longint'(-c) : longint'(c);
    den = (d == 0 ? 64'd1 : d) << 30;
    q = (mag * v * 256 + den / 2) / den;
    if (c < 0) r = q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
    else r = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(q);
    return r;
  endfunction

  function automatic command_t predict_command(longint px, longint py, longint yw);
    command_t e;
    longint dx, dy, err, aerr, c, s;
    longint unsigned adx, ady, d2, dv;
    logic far;
    int ds, dl;
    dx = goal_x - px;
    dy = goal_y - py;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    far = adx >= 64'h8000_0000 || ady >= 64'h8000_0000;
    d2 = far ? 0 : adx * adx + ady * ady;
    err = goal_yaw - yw;
    if (err > 32768) err -= 65536;
    if (err < -32768) err += 65536;
    aerr = err < 0 ? -err : err;
    ds = far ? 1 : cmp_mag(d2, d_stop * d_stop);
    dl = far ? 1 : cmp_mag(d2, d_slow * d_slow);
    lin_mode = next_mode(lin_mode, ds, dl);
    rot_mode = next_mode(rot_mode, cmp_mag(aerr, a_stop), cmp_mag(aerr, a_slow));
    e.vel_x = '0;
    e.vel_y = '0;
    e.turn_rate = '0;
    if (lin_mode != M_STOP) begin
      dv = lin_mode == M_SLOW ? slow_div : 256;
      unit_vector(heading_to_goal(dx, dy) - yw * (longint'(1) << (AB - 16)), c, s);
      e.vel_x = scaled_command(c, v_lin, dv);
      e.vel_y = scaled_command(s, v_lin, dv);
    end
    if (rot_mode != M_STOP) begin
      dv = rot_mode == M_SLOW ? slow_div : 256;
      e.turn_rate = scaled_command(err > 0 ? 1073741824 : -1073741824, v_turn, dv);
    end
    e.lin = lin_mode;
    e.rot = rot_mode;
    return e;
  endfunction

  always @(posedge clk) begin
    command_t e;
    if (!rst_n) begin
      v_lin = 13107; v_turn = 13107; slow_div = 512;
      d_stop = 6554; d_slow = 19661; a_stop = 522; a_slow = 1043;
      goal_x = 0; goal_y = 0; goal_yaw = 0;
      lin_mode = M_STOP; rot_mode = M_STOP;
      cmd_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_V_LINEAR: v_lin    = pwdata[23:0];
          REG_V_ROT:    v_turn   = pwdata[23:0];
          REG_SLOWDOWN: slow_div = pwdata[15:0];
          REG_D_STOP:   d_stop   = pwdata[30:0];
          REG_D_SLOW:   d_slow   = pwdata[30:0];
          REG_A_STOP:   a_stop   = pwdata[15:0];
          REG_A_SLOW:   a_slow   = pwdata[15:0];
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (cmd_q.size() == 0) begin
          $error("command beat with nothing expected");
          fail_count++;
        end else begin
          e = cmd_q.pop_front();
          cmds_checked++;
          if (cmd_mon.vel_x !== e.vel_x) begin
            $error("vel_x expected %0d got %0d", $signed(e.vel_x), cmd_mon.vel_x);
            fail_count++;
          end
          if (cmd_mon.vel_y !== e.vel_y) begin
            $error("vel_y expected %0d got %0d", $signed(e.vel_y), cmd_mon.vel_y);
            fail_count++;
          end
          if (cmd_mon.turn_rate !== e.turn_rate) begin
            $error("turn_rate expected %0d got %0d", $signed(e.turn_rate),
                   cmd_mon.turn_rate);
            fail_count++;
          end
          if (cmd_mon.linear_mode !== e.lin) begin
            $error("linear_mode expected %0d got %0d", e.lin, cmd_mon.linear_mode);
            fail_count++;
          end
          if (cmd_mon.rotate_mode !== e.rot) begin
            $error("rotate_mode expected %0d got %0d", e.rot, cmd_mon.rotate_mode);
            fail_count++;
          end
        end
      end
      if (pose_mon.valid && pose_mon.ready) begin
        if (pose_mon.opcode == OP_GOAL) begin
          goal_x = pose_mon.pos_x;
          goal_y = pose_mon.pos_y;
          goal_yaw = pose_mon.yaw;
        end else begin
          cmd_q.push_back(predict_command(pose_mon.pos_x, pose_mon.pos_y, pose_mon.yaw));
        end
      end
    end
    cmds_pending = cmd_q.size();
  end

  initial begin
    fail_count = 0;
    cmds_pending = 0;
    cmds_checked = 0;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives goal and odometry beats and register writes into the go-to-pose
// controller through several register settings, stalls both channels at
// random, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import gtp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int cmds_pending;
  int cmds_checked;

  // stall controls: drop all stalls on both channels, or hold the receiver off once
  logic no_idle;
  logic hold_off;
  int   beats_sent;

  // goal as last sent, so odometry can be placed around it
  int          cur_gx;
  int          cur_gy;
  logic [15:0] cur_gyaw;

  gtp_in_if  pose_if ();
  gtp_out_if cmd_if ();

  go_to_pose_velocity_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pose_if),
    .out_chan (cmd_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  gtp_cmd_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pose_mon     (pose_if),
    .cmd_mon      (cmd_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .cmds_pending (cmds_pending),
    .cmds_checked (cmds_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Write one register: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one pose beat after a random gap; keep valid high across back-to-back
  // beats so it is never lowered and raised in the same step.
  task automatic send_pose(input logic op, input int x, input int y,
                           input logic [15:0] yw);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      pose_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose_if.valid  <= 1'b1;
    pose_if.opcode <= op;
    pose_if.pos_x  <= x;
    pose_if.pos_y  <= y;
    pose_if.yaw    <= yw;
    do @(posedge clk); while (!pose_if.ready);
    beats_sent++;
    if (op == OP_GOAL) begin
      cur_gx = x;
      cur_gy = y;
      cur_gyaw = yw;
    end
  endtask

  // Hold the sender until every command is back, then let the block settle.
  task automatic drain();
    pose_if.valid <= 1'b0;
    do @(posedge clk); while (cmds_pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic directed_beats();
    send_pose(OP_ODOM, 0, 0, 16'sd0);
    send_pose(OP_GOAL, 65536, 0, 16'sd1000);
    send_pose(OP_ODOM, 0, 0, 16'sd0);
    send_pose(OP_ODOM, 0, 0, 16'h8000);
    send_pose(OP_ODOM, 60000, 0, 16'h7FFF);
    send_pose(OP_ODOM, 65536, 0, 16'sd1000);
    send_pose(OP_ODOM, 50000, 10000, 16'sd1600);
    send_pose(OP_GOAL, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    send_pose(OP_ODOM, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
    send_pose(OP_ODOM, 0, 0, 16'sd0);
    send_pose(OP_GOAL, 0, 100000, 16'sd0);
    send_pose(OP_ODOM, 0, 0, 16'sd16384);
    send_pose(OP_ODOM, 0, 0, -16'sd16384);
    send_pose(OP_ODOM, -1, -1, 16'sd5);
    send_pose(OP_GOAL, -70000, -70000, 16'sd500);
    send_pose(OP_ODOM, 0, 0, 16'sd0);
    send_pose(OP_ODOM, 0, 0, 16'sd500);
    send_pose(OP_ODOM, -70000, 0, 16'h8000);
    send_pose(OP_ODOM, -70000, -70000, 16'sd500);
  endtask

  // Mostly odometry scattered around the current goal at random scales, with some
  // new goals and the odd fully random beat.
  task automatic random_beats(input int n);
    int off_x, off_y;
    logic [15:0] dyaw;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) no_idle = ~no_idle;
      case ($urandom_range(0, 9))
        0: send_pose($urandom_range(0, 1), $urandom, $urandom, $urandom);
        1: send_pose(OP_GOAL, int'($urandom) >>> $urandom_range(0, 16),
                     int'($urandom) >>> $urandom_range(0, 16), $urandom);
        default: begin
          off_x = int'($urandom) >>> $urandom_range(0, 31);
          off_y = int'($urandom) >>> $urandom_range(0, 31);
          dyaw  = 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
          send_pose(OP_ODOM, cur_gx - off_x, cur_gy - off_y, cur_gyaw - dyaw);
        end
      endcase
    end
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int stall;
    cmd_if.ready = 1'b0;
    forever begin
      if (hold_off) begin
        cmd_if.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 18);
        if (stall > 0) begin
          cmd_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      cmd_if.ready <= 1'b1;
      do @(posedge clk); while (!cmd_if.valid);
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pose_if.valid = 1'b0;
    pose_if.opcode = 1'b0;
    pose_if.pos_x = '0;
    pose_if.pos_y = '0;
    pose_if.yaw = '0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    beats_sent = 0;
    cur_gx = 0;
    cur_gy = 0;
    cur_gyaw = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults first
    directed_beats();
    random_beats(200);
    drain();

    // extremes: top speeds, slowdown of one, widest windows; fill the block
    // while the receiver holds off
    reg_write(REG_V_LINEAR, 32'h00FF_FFFF);
    reg_write(REG_V_ROT, 32'h00FF_FFFF);
    reg_write(REG_SLOWDOWN, 32'd1);
    reg_write(REG_D_STOP, 32'd0);
    reg_write(REG_D_SLOW, 32'h7FFF_FFFF);
    reg_write(REG_A_STOP, 32'd0);
    reg_write(REG_A_SLOW, 32'd32768);
    hold_off = 1'b1;
    random_beats(250);
    drain();

    // opposite extremes, zero slowdown and zero speeds
    reg_write(REG_V_LINEAR, 32'd0);
    reg_write(REG_V_ROT, 32'd0);
    reg_write(REG_SLOWDOWN, 32'd0);
    reg_write(REG_D_STOP, 32'h7FFF_FFFF);
    reg_write(REG_D_SLOW, 32'd0);
    reg_write(REG_A_STOP, 32'd32768);
    reg_write(REG_A_SLOW, 32'd0);
    random_beats(150);
    drain();

    // random settings at assorted scales
    for (int p = 0; p < 4; p++) begin
      reg_write(REG_V_LINEAR, $urandom_range(0, 24'hFF_FFFF));
      reg_write(REG_V_ROT, $urandom_range(0, 24'hFF_FFFF));
      reg_write(REG_SLOWDOWN, $urandom_range(1, 65535));
      reg_write(REG_D_STOP, $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24));
      reg_write(REG_D_SLOW, $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24));
      reg_write(REG_A_STOP, $urandom_range(0, 32768) >> $urandom_range(0, 8));
      reg_write(REG_A_SLOW, $urandom_range(0, 32768) >> $urandom_range(0, 8));
      random_beats(235);
      drain();
    end

    $display("Run covered %0d pose beats and %0d checked commands over seven register",
             beats_sent, cmds_checked);
    $display("settings, with stalls on both channels and one long receiver hold-off.");
    if (fail_count == 0 && cmds_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up well beyond the slowest correct run.
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
